/* hdl/rgbmf_pkg.sv */
// Shared types, constants and helper functions for the RGB 3x3 median filter.
// No dependencies; imported by rgbmf_median and rgb_median_filter_3x3.
package rgbmf_pkg;

    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int NUM_CH     = 3;
    localparam int WIN_N      = 9;
    localparam int RANK_W     = 4;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_W_BITS = 11;
    localparam int CFG_H_BITS = 13;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [RANK_W-1:0] RANK_LO = RANK_W'(3);
    localparam logic [RANK_W-1:0] RANK_HI = RANK_W'(4);

    localparam logic [CH_W-1:0] PAD_LOW  = '0;
    localparam logic [CH_W-1:0] PAD_HIGH = '1;

    typedef logic [WIN_N-1:0][CH_W-1:0] chan_win_t;
    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic top_v;
        logic bot_v;
        logic left_v;
        logic right_v;
    } job_t;

    // Mark the invalid slots that take the low pad value: the first
    // floor(invalid/2) of them. The rest take the high pad value.
    function automatic logic [WIN_N-1:0] pad_low_mask(input logic [WIN_N-1:0] vmask);
        logic [RANK_W-1:0] n_inv;
        logic [RANK_W-1:0] seen;
        logic [WIN_N-1:0]  res;
        n_inv = '0;
        seen  = '0;
        res   = '0;
        for (int i = 0; i < WIN_N; i++) begin
            if (!vmask[i]) begin
                n_inv = n_inv + RANK_W'(1);
            end
        end
        for (int i = 0; i < WIN_N; i++) begin
            if (!vmask[i]) begin
                if (seen < (n_inv >> 1)) begin
                    res[i] = 1'b1;
                end
                seen = seen + RANK_W'(1);
            end
        end
        return res;
    endfunction

endpackage

/* hdl/rgb_median_filter_3x3.sv */
// Top level of the RGB 3x3 median filter: line stores, window and control.
// Depends on rgbmf_pkg, rgbmf_ram and rgbmf_median.
//
// Takes one transaction per clock unless the output stalls, and gives at most
// one result per transaction. Each channel is replaced by the median of its 3x3
// neighborhood clipped at the frame borders (floor of the mean of the two
// middle values for an even count). The result for a pixel becomes due
// image_width+1 transactions after that pixel arrives, passes the window, padding,
// median and output registers, and leaves the block; after the last pixel of a
// frame send image_width+1 flush transactions to drain it. A flush before the
// frame is complete is accepted and ignored; a pixel after it acts as a flush.
// The two line stores (MAX_WIDTH x 24 bits each) are read and written back
// once per transaction, which sets the rate of one transaction per clock; a
// one-entry forward covers the back-to-back access of a one-pixel-wide frame.
// A configuration write restarts the frame position.
module rgb_median_filter_3x3
    import rgbmf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_op,
    input  logic [CH_W-1:0]       s_red_in,
    input  logic [CH_W-1:0]       s_green_in,
    input  logic [CH_W-1:0]       s_blue_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CH_W-1:0]       m_red_out,
    output logic [CH_W-1:0]       m_green_out,
    output logic [CH_W-1:0]       m_blue_out,
    output logic                  m_frame_end
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int LW  = $clog2(MAX_WIDTH + 2);
    localparam int HHW = $clog2(MAX_HEIGHT + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 2);
    localparam int HR  = $clog2(MAX_HEIGHT);
    localparam int W_RST = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
    localparam int H_RST = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

    logic [WW-1:0]  w_reg;
    logic [HHW-1:0] h_reg;
    logic [CW-1:0]  px_reg;
    logic [HW-1:0]  py_reg;
    logic [LW-1:0]  lead_reg;
    logic [CW-1:0]  ocol_reg;
    logic [HR-1:0]  orow_reg;

    logic [31:0]    cfg_val_w;
    logic [31:0]    cfg_val_h;
    logic [WW-1:0]  w_clamped;
    logic [HHW-1:0] h_clamped;

    logic adv;
    logic accept;
    logic full;
    logic step;
    logic emit;
    logic last;
    logic cfg_we;

    job_t job_next;

    logic          s1_valid_reg;
    logic [CW-1:0] s1_px_reg;
    pix_t          s1_pix_reg;
    job_t          s1_job_reg;
    logic          fwd_reg;
    pix_t          pend_reg;

    pix_t upper_rd;
    pix_t lower_rd;
    pix_t upper_col;
    pix_t pix_in;

    logic [2:0][2:0][PIX_W-1:0] win_reg;
    job_t                       job2_reg;
    job_t                       job3_reg;
    job_t                       job4_reg;
    job_t                       job5_reg;

    logic [WIN_N-1:0] vmask;
    logic [WIN_N-1:0] pad_lo;
    logic [2:0]       row_v;
    logic [2:0]       col_v;
    logic [RANK_W-1:0] n_valid;
    chan_win_t        vals_next [NUM_CH];
    chan_win_t        vals3_reg [NUM_CH];
    logic             odd3_reg;
    logic [CH_W-1:0]  med [NUM_CH];

    logic            m_valid_reg;
    logic [CH_W-1:0] m_red_reg;
    logic [CH_W-1:0] m_green_reg;
    logic [CH_W-1:0] m_blue_reg;
    logic            m_last_reg;

    assign adv       = !m_valid_reg || m_ready;
    assign s_ready   = adv;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign full      = py_reg >= HW'(h_reg);
    assign step      = accept && ((s_op == OP_PIXEL) || full);
    assign emit      = step && (lead_reg == LW'(w_reg) + LW'(1));
    assign last      = (HHW'(orow_reg) == h_reg - HHW'(1)) && (WW'(ocol_reg) == w_reg - WW'(1));
    assign pix_in    = {s_red_in, s_green_in, s_blue_in};

    assign cfg_val_w = 32'(cfg_wdata[CFG_W_BITS-1:0]);
    assign cfg_val_h = 32'(cfg_wdata[CFG_H_BITS-1:0]);
    assign w_clamped = (cfg_val_w == 32'd0) ? WW'(1) :
                       (cfg_val_w > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_val_w);
    assign h_clamped = (cfg_val_h == 32'd0) ? HHW'(1) :
                       (cfg_val_h > 32'(MAX_HEIGHT)) ? HHW'(MAX_HEIGHT) : HHW'(cfg_val_h);

    always_comb begin
        job_next.valid   = emit;
        job_next.last    = last;
        job_next.top_v   = orow_reg != '0;
        job_next.bot_v   = (HHW'(orow_reg) + HHW'(1)) < h_reg;
        job_next.left_v  = ocol_reg != '0;
        job_next.right_v = (WW'(ocol_reg) + WW'(1)) < w_reg;
    end

    // Frame size registers, frame position, lead count and result position.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg    <= WW'(W_RST);
            h_reg    <= HHW'(H_RST);
            px_reg   <= '0;
            py_reg   <= '0;
            lead_reg <= '0;
            ocol_reg <= '0;
            orow_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_WIDTH:  w_reg <= w_clamped;
                REG_HEIGHT: h_reg <= h_clamped;
                default:    w_reg <= w_reg;
            endcase
            px_reg   <= '0;
            py_reg   <= '0;
            lead_reg <= '0;
            ocol_reg <= '0;
            orow_reg <= '0;
        end else if (step) begin
            if (emit && last) begin
                px_reg   <= '0;
                py_reg   <= '0;
                lead_reg <= '0;
                ocol_reg <= '0;
                orow_reg <= '0;
            end else begin
                if (WW'(px_reg) + WW'(1) == w_reg) begin
                    px_reg <= '0;
                    py_reg <= py_reg + HW'(1);
                end else begin
                    px_reg <= px_reg + CW'(1);
                end
                if (!emit) begin
                    lead_reg <= lead_reg + LW'(1);
                end else if (WW'(ocol_reg) + WW'(1) == w_reg) begin
                    ocol_reg <= '0;
                    orow_reg <= orow_reg + HR'(1);
                end else begin
                    ocol_reg <= ocol_reg + CW'(1);
                end
            end
        end
    end

    rgbmf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_lower_ram (
        .aclk  (aclk),
        .we    (step),
        .waddr (px_reg),
        .wdata (pix_in),
        .re    (adv),
        .raddr (px_reg),
        .rdata (lower_rd)
    );

    rgbmf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper_ram (
        .aclk  (aclk),
        .we    (adv && s1_valid_reg),
        .waddr (s1_px_reg),
        .wdata (lower_rd),
        .re    (adv),
        .raddr (px_reg),
        .rdata (upper_rd)
    );

    assign upper_col = fwd_reg ? pend_reg : upper_rd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
            job2_reg     <= '0;
            job3_reg     <= '0;
            job4_reg     <= '0;
            job5_reg     <= '0;
        end else if (adv) begin
            s1_valid_reg <= step;
            fwd_reg      <= step && s1_valid_reg && (px_reg == s1_px_reg);
            job2_reg     <= s1_valid_reg ? s1_job_reg : '0;
            job3_reg     <= job2_reg;
            job4_reg     <= job3_reg;
            job5_reg     <= job4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_px_reg  <= px_reg;
            s1_pix_reg <= pix_in;
            s1_job_reg <= job_next;
            pend_reg   <= lower_rd;
            if (s1_valid_reg) begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= {s1_pix_reg, lower_rd, upper_col};
            end
            vals3_reg <= vals_next;
            odd3_reg  <= n_valid[0];
        end
    end

    assign row_v  = {job2_reg.bot_v, 1'b1, job2_reg.top_v};
    assign col_v  = {job2_reg.right_v, 1'b1, job2_reg.left_v};

    always_comb begin
        n_valid = '0;
        for (int i = 0; i < WIN_N; i++) begin
            vmask[i] = row_v[i / 3] && col_v[i % 3];
            n_valid  = n_valid + RANK_W'(vmask[i]);
        end
    end

    assign pad_lo = pad_low_mask(vmask);

    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            for (int i = 0; i < WIN_N; i++) begin
                if (vmask[i]) begin
                    vals_next[k][i] = win_reg[i % 3][i / 3][PIX_W-1-CH_W*k -: CH_W];
                end else if (pad_lo[i]) begin
                    vals_next[k][i] = PAD_LOW;
                end else begin
                    vals_next[k][i] = PAD_HIGH;
                end
            end
        end
    end

    for (genvar g = 0; g < NUM_CH; g++) begin : g_med
        rgbmf_median u_median (
            .aclk   (aclk),
            .en     (adv),
            .vals_i (vals3_reg[g]),
            .odd_i  (odd3_reg),
            .med_o  (med[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= job5_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_red_reg   <= med[0];
            m_green_reg <= med[1];
            m_blue_reg  <= med[2];
            m_last_reg  <= job5_reg.last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_red_out   = m_red_reg;
    assign m_green_out = m_green_reg;
    assign m_blue_out  = m_blue_reg;
    assign m_frame_end = m_last_reg;

    a_ocol_range: assert property (@(posedge aclk) disable iff (!aresetn)
        WW'(ocol_reg) < w_reg)
        else $error("result column beyond frame width");

    a_orow_range: assert property (@(posedge aclk) disable iff (!aresetn)
        HHW'(orow_reg) < h_reg)
        else $error("result row beyond frame height");

    a_lead_range: assert property (@(posedge aclk) disable iff (!aresetn)
        lead_reg <= LW'(w_reg) + LW'(1))
        else $error("lead count overran its limit");

    a_fwd_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_reg |-> s1_valid_reg)
        else $error("line store forward without a pending transaction");

    a_emit_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && job2_reg.valid) |=> job3_reg.valid)
        else $error("window job lost between stages");

endmodule

/* hdl/rgbmf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for the line stores.
module rgbmf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/rgbmf_median.sv */
// Rank-based selection of the two middle values of a padded 9-entry window,
// two register stages, then floor average for even counts. Uses rgbmf_pkg.
module rgbmf_median
    import rgbmf_pkg::*;
(
    input  logic            aclk,
    input  logic            en,
    input  chan_win_t       vals_i,
    input  logic            odd_i,
    output logic [CH_W-1:0] med_o
);

    chan_win_t                    vals4_reg;
    logic [WIN_N-1:0][RANK_W-1:0] rank4_reg;
    logic [WIN_N-1:0][RANK_W-1:0] rank_next;
    logic                         odd4_reg;
    logic [CH_W-1:0]              lo_next;
    logic [CH_W-1:0]              hi_next;
    logic [CH_W-1:0]              lo5_reg;
    logic [CH_W-1:0]              hi5_reg;
    logic                         odd5_reg;
    logic [CH_W:0]                sum;

    always_comb begin
        for (int i = 0; i < WIN_N; i++) begin
            rank_next[i] = '0;
            for (int j = 0; j < WIN_N; j++) begin
                if (j != i) begin
                    if ((vals_i[j] < vals_i[i]) || ((vals_i[j] == vals_i[i]) && (j < i))) begin
                        rank_next[i] = rank_next[i] + RANK_W'(1);
                    end
                end
            end
        end
    end

    always_comb begin
        lo_next = '0;
        hi_next = '0;
        for (int i = 0; i < WIN_N; i++) begin
            if (rank4_reg[i] == RANK_LO) begin
                lo_next = lo_next | vals4_reg[i];
            end
            if (rank4_reg[i] == RANK_HI) begin
                hi_next = hi_next | vals4_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vals4_reg <= vals_i;
            rank4_reg <= rank_next;
            odd4_reg  <= odd_i;
            lo5_reg   <= lo_next;
            hi5_reg   <= hi_next;
            odd5_reg  <= odd4_reg;
        end
    end

    assign sum   = {1'b0, lo5_reg} + {1'b0, hi5_reg};
    assign med_o = odd5_reg ? hi5_reg : sum[CH_W:1];

endmodule

/* tb/tb_rgb_median_filter_3x3.sv */
// Self-checking testbench for rgb_median_filter_3x3: raster frames of random
// size and content, flush drains, register writes and handshake stalls.
// Depends on rgbmf_pkg and the rgb_median_filter_3x3 RTL.
module tb_rgb_median_filter_3x3;
    import rgbmf_pkg::*;

    localparam int MAX_W = 1024;
    localparam int MAX_H = 4096;

    typedef struct {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            fe;
    } rgb_result_t;

    class median_scoreboard;
        logic [PIX_W-1:0] rows[4][MAX_W];
        int unsigned      width_reg, height_reg;
        longint unsigned  in_row, in_col, out_row, out_col, flush_cnt;
        rgb_result_t      due_q[$];

        function void clear();
            foreach (rows[i, j]) rows[i][j] = '0;
            width_reg  = 640;
            height_reg = 480;
            restart();
            due_q.delete();
        endfunction

        function void restart();
            in_row = 0; in_col = 0; out_row = 0; out_col = 0; flush_cnt = 0;
        endfunction

        function void write_reg(logic idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_WIDTH) width_reg = data & 16'h07FF;
            else height_reg = data & 16'h1FFF;
            restart();
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned hi);
            if (v == 0) return 1;
            return (v > hi) ? hi : v;
        endfunction

        function logic [CH_W-1:0] median(logic [CH_W-1:0] v[9], int n);
            logic [CH_W-1:0] k;
            int j;
            for (int i = 1; i < n; i++) begin
                k = v[i];
                j = i;
                while (j > 0 && v[j-1] > k) begin
                    v[j] = v[j-1];
                    j--;
                end
                v[j] = k;
            end
            if (n % 2 == 1) return v[n/2];
            return CH_W'((int'(v[n/2-1]) + int'(v[n/2])) / 2);
        endfunction

        function void note_input(logic op, logic [CH_W-1:0] r, g, b);
            longint unsigned w, h, total, received, t, o, r0, r1, c0, c1;
            logic [CH_W-1:0] cr[9], cg[9], cb[9];
            logic [PIX_W-1:0] px;
            rgb_result_t res;
            int n;
            logic full, last;
            w = clamp(width_reg, MAX_W);
            h = clamp(height_reg, MAX_H);
            total = w * h;
            full = (in_row >= h);
            received = full ? total : in_row * w + in_col;
            t = received + flush_cnt;
            o = out_row * w + out_col;
            if (!full && op == OP_FLUSH) return;
            if (!full) begin
                rows[in_row % 4][in_col] = {r, g, b};
                in_col++;
                if (in_col >= w) begin
                    in_col = 0;
                    in_row++;
                end
            end else begin
                flush_cnt++;
            end
            if (t >= o + w + 1 && o < total) begin
                r0 = (out_row > 0) ? out_row - 1 : 0;
                r1 = (out_row + 1 < h) ? out_row + 1 : h - 1;
                c0 = (out_col > 0) ? out_col - 1 : 0;
                c1 = (out_col + 1 < w) ? out_col + 1 : w - 1;
                last = (o + 1 == total);
                n = 0;
                for (longint unsigned rr = r0; rr <= r1; rr++) begin
                    for (longint unsigned cc = c0; cc <= c1; cc++) begin
                        px = rows[rr % 4][cc];
                        cr[n] = px[23:16];
                        cg[n] = px[15:8];
                        cb[n] = px[7:0];
                        n++;
                    end
                end
                res.red   = median(cr, n);
                res.green = median(cg, n);
                res.blue  = median(cb, n);
                res.fe    = last;
                due_q.push_back(res);
                out_col++;
                if (out_col >= w) begin
                    out_col = 0;
                    out_row++;
                end
                if (last) restart();
            end
        endfunction

        function string check(logic [CH_W-1:0] r, g, b, logic fe);
            rgb_result_t e;
            string s;
            if (due_q.size() == 0) return "result with no pending expectation";
            e = due_q.pop_front();
            s = "";
            if (r !== e.red) s = {s, $sformatf(" red %0d exp %0d", r, e.red)};
            if (g !== e.green) s = {s, $sformatf(" green %0d exp %0d", g, e.green)};
            if (b !== e.blue) s = {s, $sformatf(" blue %0d exp %0d", b, e.blue)};
            if (fe !== e.fe) s = {s, $sformatf(" frame_end %0b exp %0b", fe, e.fe)};
            return s;
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    logic                  aclk, aresetn;
    logic                  cfg_valid, cfg_ready, cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid, s_ready, s_op;
    logic [CH_W-1:0]       s_red_in, s_green_in, s_blue_in;
    logic                  m_valid, m_ready;
    logic [CH_W-1:0]       m_red_out, m_green_out, m_blue_out;
    logic                  m_frame_end;

    median_scoreboard sb;
    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int frames_sent = 0;
    int choke_cycles = 0;
    bit no_idle = 0;

    rgb_median_filter_3x3 DUT (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("timeout");
        $display("** rgb_median_filter_3x3: FAILED **");
        $finish;
    end

    task automatic report(string msg);
        $display("mismatch at result %0d:%s", results_seen, msg);
        errors++;
    endtask

    function automatic int gap_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 96) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [CH_W-1:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return CH_W'($urandom);
        endcase
    endfunction

    // Result side: random backpressure plus one long hold-off on request.
    initial begin
        int stall_left;
        string msg;
        stall_left = 0;
        m_ready = 0;
        forever begin
            @(negedge aclk);
            if (choke_cycles > 0) begin
                m_ready <= 0;
                choke_cycles--;
            end else if (stall_left > 0) begin
                m_ready <= 0;
                stall_left--;
            end else begin
                m_ready <= 1;
                stall_left = gap_len();
            end
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                msg = sb.check(m_red_out, m_green_out, m_blue_out, m_frame_end);
                if (msg != "") report(msg);
                results_seen++;
            end
        end
    end

    task automatic send_item(logic op, logic [CH_W-1:0] r, g, b);
        int gap;
        @(negedge aclk);
        s_valid    <= 1;
        s_op       <= op;
        s_red_in   <= r;
        s_green_in <= g;
        s_blue_in  <= b;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(op, r, g, b);
        items_sent++;
        gap = gap_len();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic send_pixel();
        send_item(OP_PIXEL, rand_byte(), rand_byte(), rand_byte());
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_wdata <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    task automatic set_size(int w, int h);
        write_reg(REG_WIDTH, {5'($urandom), 11'(w)});
        write_reg(REG_HEIGHT, {3'($urandom), 13'(h)});
    endtask

    // noisy: stray flushes mid-frame, pixels in the drain.
    task automatic send_frame(int w, int h, bit noisy);
        for (int i = 0; i < w * h; i++) begin
            if (noisy && $urandom_range(0, 9) == 0)
                send_item(OP_FLUSH, rand_byte(), rand_byte(), rand_byte());
            send_pixel();
        end
        for (int i = 0; i <= w; i++) begin
            if (noisy && $urandom_range(0, 3) == 0) send_pixel();
            else send_item(OP_FLUSH, rand_byte(), rand_byte(), rand_byte());
        end
        frames_sent++;
    endtask

    initial begin
        int w, h, nfr;
        sb = new();
        sb.clear();
        aresetn = 0;
        cfg_valid = 0; cfg_index = 0; cfg_wdata = '0;
        s_valid = 0; s_op = 0; s_red_in = '0; s_green_in = '0; s_blue_in = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        repeat (5) @(posedge aclk);

        // directed: zero sizes, 2x2, 3x3 with extreme values
        write_reg(REG_WIDTH, 16'hF800);
        write_reg(REG_HEIGHT, 16'hE000);
        send_frame(1, 1, 0);
        drain();
        set_size(2, 2);
        send_frame(2, 2, 0);
        drain();
        set_size(3, 3);
        for (int i = 0; i < 9; i++) begin
            if (i % 2 == 0) send_item(OP_PIXEL, '1, '0, '1);
            else send_item(OP_PIXEL, '0, '1, '0);
        end
        for (int i = 0; i < 4; i++) send_item(OP_FLUSH, '1, '1, '1);
        frames_sent++;
        drain();

        choke_cycles = 400;
        while (items_sent < 1000) begin
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) == 0) w = $urandom_range(13, 40);
            else w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            set_size(w, h);
            nfr = $urandom_range(1, 3);
            for (int f = 0; f < nfr; f++) send_frame(w, h, $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) == 0) begin
                for (int i = $urandom_range(1, w * h); i > 0; i--) send_pixel();
            end
            drain();
        end
        no_idle = 0;

        if (sb.pending() != 0) report($sformatf(" %0d expected results never came", sb.pending()));
        $display("run covered %0d transactions in, %0d results out, %0d frames",
                 items_sent, results_seen, frames_sent);
        $display("sizes from 1x1 up to 40x8, zero sizes, stray flushes, stalls on both sides");
        if (errors == 0) begin
            $display("** rgb_median_filter_3x3: PASSED **");
        end else begin
            $display("** rgb_median_filter_3x3: FAILED **");
        end
        $finish;
    end

endmodule
